// ===== src/mtg_pkg.sv =====
// mtg_pkg: shared constants, types and helper functions of the mt19937 generator
// used by mtg_ctrl, mtg_dp and mersenne_twister_generator; depends on nothing
`default_nettype none

package mtg_pkg;

    // generator geometry
    localparam int MT_N  = 624;
    localparam int MT_M  = 397;
    localparam int IDX_W = 10;
    localparam int KEY_DEPTH_DEF = 16;

    // arithmetic constants
    localparam logic [31:0] TWIST_XOR   = 32'h9908b0df;
    localparam logic [31:0] HIGH_BIT    = 32'h80000000;
    localparam logic [31:0] LOW_BITS    = 32'h7fffffff;
    localparam logic [31:0] TEMPER_B    = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C    = 32'hefc60000;
    localparam logic [31:0] MUL_INIT    = 32'd1812433253;
    localparam logic [31:0] MUL_ARR1    = 32'd1664525;
    localparam logic [31:0] MUL_ARR2    = 32'd1566083941;
    localparam logic [31:0] SEED_ARR    = 32'd19650218;
    localparam logic [31:0] SEED_DFLT   = 32'd5489;

    // request action codes
    typedef enum logic [1:0] {
        ACT_DRAW = 2'd0,
        ACT_SEED = 2'd1,
        ACT_KEY  = 2'd2,
        ACT_NOP  = 2'd3
    } action_t;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE, ST_KEY,
        ST_SS_INIT, ST_SS_MUL, ST_SS_WR,
        ST_SA_START, ST_SA1_RD, ST_SA1_WR, ST_SA1_WRAP,
        ST_SA2_START, ST_SA2_RD, ST_SA2_WR, ST_SA2_WRAP, ST_SA_FIN,
        ST_RG_START, ST_RG_R0, ST_RG_R1, ST_RG_R2, ST_RG_W,
        ST_DR_RD, ST_DR_OUT
    } state_t;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE, OP_KEY_STORE,
        OP_SS_INIT, OP_SS_MUL, OP_SS_WR,
        OP_SA_START, OP_SA_RD, OP_SA1_WR, OP_SA2_START, OP_SA2_WR,
        OP_WRAP0, OP_SA_FIN,
        OP_RG_START, OP_RG_R0, OP_RG_R1, OP_RG_R2, OP_RG_W,
        OP_DR_RD, OP_DR_OUT
    } op_t;

    typedef enum logic [1:0] {
        SEED_VALUE,
        SEED_DEFAULT,
        SEED_ARRAY
    } seed_sel_t;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_SA,
        RET_RG
    } ret_t;

    typedef struct packed {
        op_t       op;
        seed_sel_t seed;
        logic      mul2;
        logic      load;
    } cmd_t;

    typedef struct packed {
        logic idx_ge;
        logic idx_unseeded;
        logic i_last;
        logic k_one;
        logic k_zero;
        logic last_key;
        logic out_busy;
    } status_t;

    // one twist of the recurrence
    function automatic logic [31:0] twist(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] far);
        logic [31:0] y;
        y = (a & HIGH_BIT) | (b & LOW_BITS);
        return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
    endfunction

    // output tempering
    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y ^ (y >> 18);
    endfunction

endpackage

`default_nettype wire

// ===== src/mtg_ctrl.sv =====
// mtg_ctrl: sequencer for draw, seeding, key collection and block regeneration
// depends on mtg_pkg; drives mtg_dp through cmd_t and reads status_t
`default_nettype none

module mtg_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [1:0]      action,
    input  wire mtg_pkg::status_t st,
    output mtg_pkg::cmd_t        cmd
);
    import mtg_pkg::*;

    state_t    state_reg, state_next;
    seed_sel_t seed_reg, seed_next;
    ret_t      ret_reg, ret_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seed_reg  <= SEED_DEFAULT;
            ret_reg   <= RET_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg  <= seed_next;
            ret_reg   <= ret_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        seed_next  = seed_reg;
        ret_next   = ret_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.seed   = seed_reg;
        cmd.mul2   = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (action_t'(action))
                        ACT_DRAW:
                        begin
                            if (st.idx_ge && st.idx_unseeded)
                            begin
                                seed_next  = SEED_DEFAULT;
                                ret_next   = RET_RG;
                                state_next = ST_SS_INIT;
                            end
                            else if (st.idx_ge)
                                state_next = ST_RG_START;
                            else
                                state_next = ST_DR_RD;
                        end
                        ACT_SEED:
                        begin
                            seed_next  = SEED_VALUE;
                            ret_next   = RET_IDLE;
                            state_next = ST_SS_INIT;
                        end
                        ACT_KEY:  state_next = ST_KEY;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_KEY:
            begin
                cmd.op = OP_KEY_STORE;
                if (st.last_key)
                begin
                    seed_next  = SEED_ARRAY;
                    ret_next   = RET_SA;
                    state_next = ST_SS_INIT;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_SS_INIT:
            begin
                cmd.op     = OP_SS_INIT;
                state_next = ST_SS_MUL;
            end
            ST_SS_MUL:
            begin
                cmd.op     = OP_SS_MUL;
                state_next = ST_SS_WR;
            end
            ST_SS_WR:
            begin
                cmd.op = OP_SS_WR;
                if (st.i_last)
                begin
                    unique case (ret_reg)
                        RET_SA:  state_next = ST_SA_START;
                        RET_RG:  state_next = ST_RG_START;
                        default: state_next = ST_IDLE;
                    endcase
                end
                else
                    state_next = ST_SS_MUL;
            end
            ST_SA_START:
            begin
                cmd.op     = OP_SA_START;
                state_next = ST_SA1_RD;
            end
            ST_SA1_RD:
            begin
                cmd.op     = OP_SA_RD;
                state_next = ST_SA1_WR;
            end
            ST_SA1_WR:
            begin
                cmd.op = OP_SA1_WR;
                if (st.i_last)
                    state_next = ST_SA1_WRAP;
                else if (st.k_one)
                    state_next = ST_SA2_START;
                else
                    state_next = ST_SA1_RD;
            end
            ST_SA1_WRAP:
            begin
                cmd.op     = OP_WRAP0;
                state_next = st.k_zero ? ST_SA2_START : ST_SA1_RD;
            end
            ST_SA2_START:
            begin
                cmd.op     = OP_SA2_START;
                state_next = ST_SA2_RD;
            end
            ST_SA2_RD:
            begin
                cmd.op     = OP_SA_RD;
                cmd.mul2   = 1'b1;
                state_next = ST_SA2_WR;
            end
            ST_SA2_WR:
            begin
                cmd.op = OP_SA2_WR;
                if (st.i_last)
                    state_next = ST_SA2_WRAP;
                else if (st.k_one)
                    state_next = ST_SA_FIN;
                else
                    state_next = ST_SA2_RD;
            end
            ST_SA2_WRAP:
            begin
                cmd.op     = OP_WRAP0;
                state_next = st.k_zero ? ST_SA_FIN : ST_SA2_RD;
            end
            ST_SA_FIN:
            begin
                cmd.op     = OP_SA_FIN;
                state_next = ST_IDLE;
            end
            ST_RG_START:
            begin
                cmd.op     = OP_RG_START;
                state_next = ST_RG_R0;
            end
            ST_RG_R0:
            begin
                cmd.op     = OP_RG_R0;
                state_next = ST_RG_R1;
            end
            ST_RG_R1:
            begin
                cmd.op     = OP_RG_R1;
                state_next = ST_RG_R2;
            end
            ST_RG_R2:
            begin
                cmd.op     = OP_RG_R2;
                state_next = ST_RG_W;
            end
            ST_RG_W:
            begin
                cmd.op     = OP_RG_W;
                state_next = st.i_last ? ST_DR_RD : ST_RG_R0;
            end
            ST_DR_RD:
            begin
                cmd.op     = OP_DR_RD;
                state_next = ST_DR_OUT;
            end
            ST_DR_OUT:
            begin
                cmd.op = OP_DR_OUT;
                if (!st.out_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/mtg_dp.sv =====
// mtg_dp: state memory, key buffer, multiplier, twist and tempering datapath
// depends on mtg_pkg; operated by mtg_ctrl through cmd_t
`default_nettype none

module mtg_dp #(
    parameter int KEY_DEPTH = mtg_pkg::KEY_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mtg_pkg::cmd_t    cmd,
    input  wire logic [31:0]      value,
    input  wire logic             last_key,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic [31:0]           random_word,
    output mtg_pkg::status_t      st
);
    import mtg_pkg::*;

    localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KCW = $clog2(KEY_DEPTH + 1);
    localparam logic [IDX_W-1:0] N_IDX    = IDX_W'(MT_N);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MT_N - 1);
    localparam logic [IDX_W-1:0] M_IDX    = IDX_W'(MT_M);
    localparam logic [IDX_W-1:0] NM_IDX   = IDX_W'(MT_N - MT_M);
    localparam logic [IDX_W-1:0] NEVER    = IDX_W'(MT_N + 1);

    logic [31:0] state_mem [MT_N];
    logic [31:0] key_mem [KEY_DEPTH];

    // control registers
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [KAW-1:0]   j_reg, j_next;
    logic [KCW-1:0]   key_cnt_reg, key_cnt_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    logic [31:0] p_reg, p_next;
    logic [31:0] mul_reg, mul_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] out_reg, out_next;
    logic [31:0] rd_reg, key_rd_reg, value_reg;
    logic        last_reg;

    logic             mem_we, mem_re, key_we, key_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [31:0]      mem_wdata, seed_val, tmix;
    logic [IDX_W-1:0] i_plus, i_far;
    logic [KCW-1:0]   j_plus;

    // memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
            state_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_reg <= state_mem[mem_raddr];
        if (key_we)
            key_mem[key_cnt_reg[KAW-1:0]] <= value_reg;
        if (key_re)
            key_rd_reg <= key_mem[j_reg];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= NEVER;
            i_reg         <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            key_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            key_cnt_reg   <= key_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        mul_reg <= mul_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        out_reg <= out_next;
        if (cmd.load)
        begin
            value_reg <= value;
            last_reg  <= last_key;
        end
    end

    // seed source
    always_comb
    begin
        case (cmd.seed)
            SEED_VALUE:   seed_val = value_reg;
            SEED_ARRAY:   seed_val = SEED_ARR;
            default:      seed_val = SEED_DFLT;
        endcase
    end

    assign tmix   = p_reg ^ (p_reg >> 30);
    assign i_plus = (i_reg == LAST_IDX) ? '0 : i_reg + IDX_W'(1);
    assign i_far  = (i_reg >= NM_IDX) ? i_reg - NM_IDX : i_reg + M_IDX;
    assign j_plus = KCW'(j_reg) + KCW'(1);

    // operation decode
    always_comb
    begin
        idx_next       = idx_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        key_cnt_next   = key_cnt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        p_next         = p_reg;
        mul_next       = mul_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        key_we         = 1'b0;
        key_re         = 1'b0;
        mem_waddr      = i_reg;
        mem_raddr      = i_reg;
        mem_wdata      = p_reg;
        unique case (cmd.op)
            OP_KEY_STORE:
            begin
                if (key_cnt_reg < KCW'(KEY_DEPTH))
                begin
                    key_we       = 1'b1;
                    key_cnt_next = key_cnt_reg + KCW'(1);
                end
            end
            OP_SS_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = seed_val;
                p_next    = seed_val;
                i_next    = IDX_W'(1);
                idx_next  = N_IDX;
            end
            OP_SS_MUL:
                mul_next = MUL_INIT * tmix;
            OP_SS_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mul_reg + 32'(i_reg);
                p_next    = mem_wdata;
                i_next    = i_reg + IDX_W'(1);
            end
            OP_SA_START:
            begin
                // first mixing step uses word zero, the array seed, loaded into p as a constant
                p_next = SEED_ARR;
                i_next = IDX_W'(1);
                j_next = '0;
                k_next = N_IDX;
            end
            OP_SA2_START:
                k_next = LAST_IDX;
            OP_SA_RD:
            begin
                mem_re   = 1'b1;
                key_re   = 1'b1;
                mul_next = (cmd.mul2 ? MUL_ARR2 : MUL_ARR1) * tmix;
            end
            OP_SA1_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (rd_reg ^ mul_reg) + key_rd_reg + 32'(j_reg);
                p_next    = mem_wdata;
                i_next    = i_reg + IDX_W'(1);
                k_next    = k_reg - IDX_W'(1);
                j_next    = (j_plus >= key_cnt_reg) ? '0 : j_plus[KAW-1:0];
            end
            OP_SA2_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (rd_reg ^ mul_reg) - 32'(i_reg);
                p_next    = mem_wdata;
                i_next    = i_reg + IDX_W'(1);
                k_next    = k_reg - IDX_W'(1);
            end
            OP_WRAP0:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = p_reg;
                i_next    = IDX_W'(1);
            end
            OP_SA_FIN:
            begin
                mem_we       = 1'b1;
                mem_waddr    = '0;
                mem_wdata    = HIGH_BIT;
                idx_next     = N_IDX;
                key_cnt_next = '0;
            end
            OP_RG_START:
                i_next = '0;
            OP_RG_R0:
                mem_re = 1'b1;
            OP_RG_R1:
            begin
                mem_re    = 1'b1;
                mem_raddr = i_plus;
                a_next    = rd_reg;
            end
            OP_RG_R2:
            begin
                mem_re    = 1'b1;
                mem_raddr = i_far;
                b_next    = rd_reg;
            end
            OP_RG_W:
            begin
                mem_we    = 1'b1;
                mem_wdata = twist(a_reg, b_reg, rd_reg);
                i_next    = i_reg + IDX_W'(1);
                if (i_reg == LAST_IDX)
                    idx_next = '0;
            end
            OP_DR_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = idx_reg;
            end
            OP_DR_OUT:
            begin
                if (!(out_valid_reg && !out_ready))
                begin
                    out_valid_next = 1'b1;
                    out_next       = temper(rd_reg);
                    idx_next       = idx_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // status to the controller
    assign st.idx_ge       = (idx_reg >= N_IDX);
    assign st.idx_unseeded = (idx_reg != N_IDX);
    assign st.i_last       = (i_reg == LAST_IDX);
    assign st.k_one        = (k_reg == IDX_W'(1));
    assign st.k_zero       = (k_reg == '0);
    assign st.last_key     = last_reg;
    assign st.out_busy     = out_valid_reg & ~out_ready;

    assign out_valid   = out_valid_reg;
    assign random_word = out_reg;

endmodule

`default_nettype wire

// ===== src/mersenne_twister_generator.sv =====
// mersenne_twister_generator: top level of the 32-bit mt19937 generator
// depends on mtg_pkg, mtg_ctrl and mtg_dp
`default_nettype none

// One request at a time. A draw from a live block reads its state word, then
// tempers it into the output register, waiting while the last word is still
// held; the draw that finds the block used up first regenerates all 624
// words, since every new word needs three reads of the state memory through
// its single read port and a write. A seed request writes each word with a
// multiply step and a write step; the final key word adds the array
// initialization, a first and a second pass over the words, each word a read
// and a write. A draw before any seeding runs the default seeding first. A
// finished word waits in the output register while the next request is taken.
module mersenne_twister_generator #(
    parameter int KEY_DEPTH = mtg_pkg::KEY_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] value,
    input  wire logic        last_key,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      random_word
);
    import mtg_pkg::*;

    cmd_t    cmd;
    status_t st;

    // sequencer
    mtg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    mtg_dp #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value       (value),
        .last_key    (last_key),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .random_word (random_word),
        .st          (st)
    );

    // a draw that finds the output free always presents a word next cycle
    a_draw_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DR_OUT && !st.out_busy) |=> out_valid)
        else $error("draw finished without a result");

    // the state read for a draw is always inside the block
    a_draw_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DR_RD) |-> !st.idx_ge)
        else $error("draw read beyond the state block");

    // taking a request never overlaps datapath work
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (cmd.op == OP_NONE))
        else $error("request taken while datapath busy");

endmodule

`default_nettype wire
